// File: design/rotary_position_rotator_core_defines.svh
// ----------------------------------------------------------------------------
// rotary position rotator assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef ROTARY_POSITION_ROTATOR_CORE_DEFINES_SVH
`define ROTARY_POSITION_ROTATOR_CORE_DEFINES_SVH

// same-cycle implication, gated by reset
`define RPR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rotary core check failed");

// next-cycle implication, gated by reset
`define RPR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rotary core check failed");

`endif

// File: design/rpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpr_pkg
// types, constants and helpers of the rotary position rotator
// ----------------------------------------------------------------------------
package rpr_pkg;

  localparam int MAX_PAIRS    = 64;
  localparam int MAX_POSITION = 4096;
  localparam int CORDIC_STEPS = 24;

  localparam int IDX_W  = 6;
  localparam int POS_W  = 12;
  localparam int DATA_W = 32;
  localparam int RATE_W = 32;
  localparam int HP_W   = 7;
  localparam int ADDR_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int STEP_W = 5;
  localparam int GUARD  = 8;
  localparam int DP_W   = 42;
  localparam int Z_W    = 32;

  localparam logic [HP_W-1:0]   HEAD_PAIRS_RESET = HP_W'(64);
  localparam logic [DATA_W-1:0] KCOMP            = 32'h9B74EDA8;

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_ROTATE = 1'b1
  } req_t;

  typedef struct packed {
    req_t                      req_type;
    logic [IDX_W-1:0]          pair_index;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  x_first;
    logic signed [DATA_W-1:0]  x_second;
    logic [RATE_W-1:0]         rate_word;
    logic                      last_in_vector;
  } rpr_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  y_first;
    logic signed [DATA_W-1:0]  y_second;
    logic                      index_error;
    logic                      last_out;
  } rpr_out_t;

  typedef struct packed {
    logic                      err;
    logic                      last;
    logic signed [DP_W-1:0]    x;
    logic signed [DP_W-1:0]    y;
    logic signed [Z_W-1:0]     z;
  } rpr_vec_t;

  // atan(2^-k) in turns times 2^32
  function automatic logic [Z_W-1:0] atan_turn(input logic [STEP_W-1:0] k);
    logic [Z_W-1:0] a;
    case (k)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

  // drop guard bits with round half up, clamp to q16.16 range
  function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [DP_W-1:0] v);
    logic signed [DP_W:0]       s;
    logic [DP_W-GUARD:0]        q;
    logic signed [DATA_W-1:0]   r;
    s = {v[DP_W-1], v} + (DP_W+1)'(1 << (GUARD - 1));
    q = s[DP_W:GUARD];
    if (q[DP_W-GUARD:DATA_W-1] == '0 || q[DP_W-GUARD:DATA_W-1] == '1) begin
      r = q[DATA_W-1:0];
    end else if (q[DP_W-GUARD]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// File: design/rpr_rate_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpr_rate_mem
// turn rate table, one write port and one registered read port
// ----------------------------------------------------------------------------
module rpr_rate_mem
  import rpr_pkg::*;
(
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  logic [RATE_W-1:0]   wdata,
  input  logic                re,
  input  logic [ADDR_W-1:0]   raddr,
  output logic [RATE_W-1:0]   rdata
);

  logic [RATE_W-1:0] mem [MAX_PAIRS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read holds when not enabled so a stalled pipe keeps its rate
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/rpr_cordic_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpr_cordic_step
// one registered micro-rotation of the cordic pipe
// ----------------------------------------------------------------------------
module rpr_cordic_step
  import rpr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic [STEP_W-1:0]   step,
  input  logic                vld_in,
  input  rpr_vec_t            vec_in,
  output logic                vld_out,
  output rpr_vec_t            vec_out
);

  rpr_vec_t               vec_next;
  logic signed [DP_W-1:0] dx;
  logic signed [DP_W-1:0] dy;
  logic signed [Z_W-1:0]  da;

  always_comb begin
    dx = vec_in.y >>> step;
    dy = vec_in.x >>> step;
    da = $signed(atan_turn(step));
    vec_next = vec_in;
    if (!vec_in.err) begin
      if (!vec_in.z[Z_W-1]) begin
        vec_next.x = vec_in.x - dx;
        vec_next.y = vec_in.y + dy;
        vec_next.z = vec_in.z - da;
      end else begin
        vec_next.x = vec_in.x + dx;
        vec_next.y = vec_in.y - dy;
        vec_next.z = vec_in.z + da;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_out <= vec_next;
    end
  end

endmodule

// File: design/rotary_position_rotator_core.sv
`timescale 1ns / 1ps
// a rotate word passes table read, scale and phase multiply, quadrant turn,
//   24 cordic steps and the output register before it shows on out_data
// throughput: one word per cycle; the whole pipe halts only while out is stalled
// load words write the rate table at acceptance and give no output word
// reset: clears pipe valids and sets head_pairs to 64; the table is not cleared
// ----------------------------------------------------------------------------
// rotary_position_rotator_core
// rotary position embedding of one element pair through a pipelined cordic
// ----------------------------------------------------------------------------
module rotary_position_rotator_core
  import rpr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [HP_W-1:0]  cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  rpr_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rpr_out_t         out_data
);

  logic                      adv;
  logic                      acc;
  logic                      in_err;
  logic [POS_W-1:0]          in_pos;
  logic [HP_W-1:0]           head_pairs;

  logic                      mem_we;
  logic                      mem_re;
  logic [RATE_W-1:0]         rate_rd;

  logic                      s1_vld;
  logic                      s1_err;
  logic                      s1_last;
  logic [POS_W-1:0]          s1_pos;
  logic signed [DATA_W-1:0]  s1_a;
  logic signed [DATA_W-1:0]  s1_b;
  logic signed [64:0]        prod_a;
  logic signed [64:0]        prod_b;

  logic                      s2_vld;
  logic                      s2_err;
  logic                      s2_last;
  logic [Z_W-1:0]            s2_phase;
  logic signed [DP_W-1:0]    s2_x;
  logic signed [DP_W-1:0]    s2_y;

  logic [1:0]                quad;
  logic [Z_W-1:0]            phase_q;
  rpr_vec_t                  vec0_next;

  logic                      vld_chain [CORDIC_STEPS+1];
  rpr_vec_t                  vec_chain [CORDIC_STEPS+1];

  rpr_out_t                  out_next;

  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign acc       = in_valid && adv;
  assign cfg_ready = 1'b1;

  assign in_err = (HP_W'(in_data.pair_index) >= head_pairs) ||
                  (32'(in_data.pair_index) >= MAX_PAIRS);
  assign in_pos = POS_W'(in_data.position % MAX_POSITION);

  always_ff @(posedge clk) begin
    if (rst) begin
      head_pairs <= HEAD_PAIRS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      head_pairs <= cfg_data;
    end
  end

  // a load and a later rotate never share an edge, so no forwarding path
  assign mem_we = acc && in_data.req_type == REQ_LOAD &&
                  32'(in_data.pair_index) < MAX_PAIRS;
  assign mem_re = acc && in_data.req_type == REQ_ROTATE;

  rpr_rate_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (ADDR_W'(in_data.pair_index)),
    .wdata (in_data.rate_word),
    .re    (mem_re),
    .raddr (ADDR_W'(in_data.pair_index)),
    .rdata (rate_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= mem_re;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_err  <= in_err;
      s1_last <= in_data.last_in_vector;
      s1_pos  <= in_pos;
      s1_a    <= in_data.x_first;
      s1_b    <= in_data.x_second;
    end
  end

  // gain compensation and phase
  assign prod_a = s1_a * $signed({1'b0, KCOMP});
  assign prod_b = s1_b * $signed({1'b0, KCOMP});

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_err   <= s1_err;
      s2_last  <= s1_last;
      s2_phase <= Z_W'(s1_pos * rate_rd);
      if (s1_err) begin
        s2_x <= DP_W'(s1_a) <<< GUARD;
        s2_y <= DP_W'(s1_b) <<< GUARD;
      end else begin
        s2_x <= DP_W'(prod_a >>> (DATA_W - GUARD));
        s2_y <= DP_W'(prod_b >>> (DATA_W - GUARD));
      end
    end
  end

  // quarter turn, residual in [-1/8, 1/8) turn
  always_comb begin
    phase_q          = s2_phase + 32'h2000_0000;
    quad             = phase_q[Z_W-1:Z_W-2];
    vec0_next.err    = s2_err;
    vec0_next.last   = s2_last;
    vec0_next.z      = $signed(s2_phase - {quad, {(Z_W-2){1'b0}}});
    vec0_next.x      = s2_x;
    vec0_next.y      = s2_y;
    if (!s2_err) begin
      case (quad)
        2'd1: begin
          vec0_next.x = -s2_y;
          vec0_next.y = s2_x;
        end
        2'd2: begin
          vec0_next.x = -s2_x;
          vec0_next.y = -s2_y;
        end
        2'd3: begin
          vec0_next.x = s2_y;
          vec0_next.y = -s2_x;
        end
        default: begin
          vec0_next.x = s2_x;
          vec0_next.y = s2_y;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_chain[0] <= 1'b0;
    end else if (adv) begin
      vld_chain[0] <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vec_chain[0] <= vec0_next;
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
    rpr_cordic_step u_step (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .step    (STEP_W'(g)),
      .vld_in  (vld_chain[g]),
      .vec_in  (vec_chain[g]),
      .vld_out (vld_chain[g+1]),
      .vec_out (vec_chain[g+1])
    );
  end

  always_comb begin
    out_next.y_first     = round_sat(vec_chain[CORDIC_STEPS].x);
    out_next.y_second    = round_sat(vec_chain[CORDIC_STEPS].y);
    out_next.index_error = vec_chain[CORDIC_STEPS].err;
    out_next.last_out    = vec_chain[CORDIC_STEPS].last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld_chain[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= out_next;
    end
  end

endmodule

// File: design/rpr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpr_checker
// port-level checks of the rotary position rotator, bound to the top level
// ----------------------------------------------------------------------------
`include "rotary_position_rotator_core_defines.svh"

module rpr_checker
  import rpr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  logic      out_valid,
  input  logic      out_stall,
  input  rpr_out_t  out_data
);

  // a stalled output word holds
  `RPR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // input backpressure comes only from a stalled output word
  `RPR_ASSERT_NOW(a_stall_src, in_stall, out_valid && out_stall)

  // the pipe is empty right after reset
  `RPR_ASSERT_NOW(a_reset_empty, $fell(rst), !out_valid)

  // handshake lines are never unknown out of reset
  `RPR_ASSERT_NOW(a_known_ctl, 1'b1, !$isunknown({out_valid, in_stall}))

endmodule

bind rotary_position_rotator_core rpr_checker u_rpr_checker (.*);

// File: tb/rotary_position_rotator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_position_rotator_core_tb
// self-checking bench for the rotary position rotator: fills the rate table,
// drives directed angle, saturation and pair range cases, then random traffic
// over several head_pairs settings. A cordic predictor queues the
// expected word for each rotate, and the output process checks every word.
// Random idling on both sides, one long output hold-off to fill the pipe.
// ----------------------------------------------------------------------------
module rotary_position_rotator_core_tb;
  import rpr_pkg::*;

  localparam int     SETTLE_CYCLES = 40;
  localparam int     PHASE_WORDS   = 100;
  localparam longint INV_GAIN      = 64'd2608131496;
  localparam longint ATAN_TURNS [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
    64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  logic            clk = 1'b0;
  logic            rst;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [HP_W-1:0] cfg_data;
  logic            in_valid;
  logic            in_stall;
  rpr_in_t         in_data;
  logic            out_valid;
  logic            out_stall;
  rpr_out_t        out_data;

  logic [RATE_W-1:0] rate_table [MAX_PAIRS];
  logic [HP_W-1:0]   head_pairs_now;
  rpr_out_t          expected_pairs [$];

  int in_gap_max;
  int out_gap_max;
  int hold_request;
  int errors;
  int rotations;
  int out_of_range;
  int loads;
  int hp_writes;
  int words_checked;
  int in_stall_cycles;

  rotary_position_rotator_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [DATA_W-1:0] round_to_q16(longint v);
    longint q;
    q = (v + 128) >>> 8;
    if (q > 64'sd2147483647) begin
      q = 64'sd2147483647;
    end else if (q < -64'sd2147483648) begin
      q = -64'sd2147483648;
    end
    return q[DATA_W-1:0];
  endfunction

  function automatic rpr_out_t predict_rotation(rpr_in_t w);
    rpr_out_t    r;
    logic [31:0] phase;
    logic [31:0] biased;
    logic [1:0]  quad;
    int          residual;
    longint      x, y, z, t, dx, dy;
    r.last_out = w.last_in_vector;
    if (w.pair_index >= head_pairs_now) begin
      r.y_first     = w.x_first;
      r.y_second    = w.x_second;
      r.index_error = 1'b1;
      return r;
    end
    phase    = w.position * rate_table[w.pair_index];
    biased   = phase + 32'h2000_0000;
    quad     = biased[31:30];
    residual = phase - {quad, 30'd0};
    z = longint'(residual);
    x = (longint'($signed(w.x_first)) * INV_GAIN) >>> 24;
    y = (longint'($signed(w.x_second)) * INV_GAIN) >>> 24;
    case (quad)
      2'd1: begin
        t = x; x = -y; y = t;
      end
      2'd2: begin
        x = -x; y = -y;
      end
      2'd3: begin
        t = x; x = y; y = -t;
      end
      default: ;
    endcase
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TURNS[k];
      end else begin
        x += dx; y -= dy; z += ATAN_TURNS[k];
      end
    end
    r.y_first     = round_to_q16(x);
    r.y_second    = round_to_q16(y);
    r.index_error = 1'b0;
    return r;
  endfunction

  function automatic rpr_in_t pack_word(req_t req, logic [IDX_W-1:0] idx,
                                        logic [POS_W-1:0] pos, logic [31:0] xf,
                                        logic [31:0] xs, logic [31:0] rate,
                                        logic last);
    rpr_in_t w;
    w.req_type       = req;
    w.pair_index     = idx;
    w.position       = pos;
    w.x_first        = xf;
    w.x_second       = xs;
    w.rate_word      = rate;
    w.last_in_vector = last;
    return w;
  endfunction

  function automatic logic [31:0] random_q16();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(0, 262143)) - 32'd131072;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] random_rate();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 1 << 20);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [POS_W-1:0] random_position();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return POS_W'($urandom_range(0, MAX_POSITION - 1));
    endcase
  endfunction

  task automatic send_word(input rpr_in_t w);
    rpr_out_t want;
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do begin
      @(posedge clk);
      if (in_stall) in_stall_cycles++;
    end while (in_stall);
    if (w.req_type == REQ_LOAD) begin
      rate_table[w.pair_index] = w.rate_word;
      loads++;
    end else begin
      want = predict_rotation(w);
      if (want.index_error) out_of_range++;
      rotations++;
      expected_pairs = {expected_pairs, want};
    end
  endtask

  task automatic load_rate(input logic [IDX_W-1:0] idx, input logic [31:0] rate);
    send_word(pack_word(REQ_LOAD, idx, random_position(), random_q16(), random_q16(),
                        rate, 1'($urandom_range(0, 1))));
  endtask

  task automatic rotate(input logic [IDX_W-1:0] idx, input logic [POS_W-1:0] pos,
                        input logic [31:0] xf, input logic [31:0] xs, input logic last);
    send_word(pack_word(REQ_ROTATE, idx, pos, xf, xs, $urandom(), last));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_head_pairs(input logic [HP_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    head_pairs_now = value;
    hp_writes++;
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endtask

  // output side: random stall per word, optional long hold-off, checks each word
  initial begin
    rpr_out_t want;
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        out_stall <= 1'b1;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end else begin
        n = $urandom_range(0, out_gap_max);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      words_checked++;
      if (expected_pairs.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual %h", $time, out_data);
      end else begin
        want = expected_pairs.pop_front();
        check_field("y_first", want.y_first, out_data.y_first);
        check_field("y_second", want.y_second, out_data.y_second);
        check_field("index_error", 32'(want.index_error), 32'(out_data.index_error));
        check_field("last_out", 32'(want.last_out), 32'(out_data.last_out));
      end
    end
  end

  // every entry gets written before any rotate reads it
  task automatic test_table_fill();
    for (int i = 0; i < MAX_PAIRS; i++) begin
      load_rate(IDX_W'(i),
                (i == 0) ? 32'h0 : (i == MAX_PAIRS - 1) ? 32'hFFFF_FFFF : random_rate());
    end
  endtask

  task automatic test_angles();
    load_rate(0, 32'h4000_0000);
    load_rate(1, 32'h2000_0000);
    load_rate(2, 32'hE000_0000);
    load_rate(3, 32'h1FFF_FFFF);
    // quarter turns through every quadrant
    for (int p = 0; p < 4; p++) begin
      rotate(0, POS_W'(p), 32'h0001_0000, 32'h0000_8000, p[0]);
    end
    // odd multiples of 45 degrees on full scale inputs saturate
    rotate(1, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    rotate(1, 3, 32'h8000_0000, 32'h8000_0000, 1'b0);
    rotate(1, 5, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    // quadrant boundaries
    rotate(2, 1, 32'h0001_0000, 32'hFFFF_0000, 1'b0);
    rotate(3, 1, 32'h0001_0000, 32'h0001_0000, 1'b1);
    rotate(0, 4095, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    rotate(63, 4095, 32'h0000_0000, 32'h0000_0000, 1'b1);
    rotate(63, 4095, 32'h1234_5678, 32'hEDCB_A988, 1'b0);
  endtask

  task automatic test_pair_range();
    wait_idle();
    write_head_pairs(1);
    rotate(0, 100, 32'h0002_0000, 32'h0003_0000, 1'b0);
    rotate(1, 100, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    rotate(63, 4095, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    // loads are not limited by head_pairs
    load_rate(63, 32'h0123_4567);
    wait_idle();
    write_head_pairs(64);
    rotate(63, 77, 32'h0001_0000, 32'h0000_0000, 1'b1);
    wait_idle();
    write_head_pairs(63);
    rotate(63, 77, 32'h0001_0000, 32'h0000_0000, 1'b1);
    rotate(62, 77, 32'h0001_0000, 32'h0000_0000, 1'b0);
  endtask

  // output held off while input keeps streaming, pipe must fill and stall
  task automatic test_backpressure();
    wait_idle();
    write_head_pairs(64);
    in_gap_max   = 0;
    hold_request = 150;
    for (int i = 0; i < 60; i++) begin
      rotate(IDX_W'($urandom_range(0, 63)), random_position(), random_q16(), random_q16(),
             1'($urandom_range(0, 1)));
    end
    in_gap_max = 10;
  endtask

  task automatic test_random_phases();
    logic [HP_W-1:0] hp;
    for (int ph = 0; ph < 10; ph++) begin
      wait_idle();
      case (ph)
        0: hp = 1;
        1: hp = 64;
        2: hp = 33;
        3: hp = 7;
        4: hp = 2;
        5: hp = 63;
        6: hp = 48;
        7: hp = 64;
        default: hp = HP_W'($urandom_range(1, 64));
      endcase
      write_head_pairs(hp);
      // some phases drop input or output idling, and one runs with none at all
      in_gap_max  = (ph % 3 == 1) ? 0 : 10;
      out_gap_max = (ph % 4 == 3) ? 0 : 10;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          load_rate(IDX_W'($urandom_range(0, 63)), random_rate());
        end else begin
          rotate(IDX_W'($urandom_range(0, 63)), random_position(), random_q16(),
                 random_q16(), 1'($urandom_range(0, 1)));
        end
      end
    end
    in_gap_max  = 10;
    out_gap_max = 10;
  endtask

  initial begin
    errors = 0; rotations = 0; out_of_range = 0; loads = 0;
    hp_writes = 0; words_checked = 0; in_stall_cycles = 0;
    in_gap_max = 10; out_gap_max = 10; hold_request = 0;
    head_pairs_now = 7'd64;
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_table_fill();
    test_angles();
    test_pair_range();
    test_backpressure();
    test_random_phases();
    wait_idle();
    $display("covered %0d rotates (%0d out of range), %0d table loads, %0d head_pairs writes",
             rotations, out_of_range, loads, hp_writes);
    $display("%0d result words checked, input stalled for %0d cycles",
             words_checked, in_stall_cycles);
    if (errors == 0) begin
      $display("[rotary_position_rotator_core] OK");
    end else begin
      $display("[rotary_position_rotator_core] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d words outstanding", expected_pairs.size());
    $display("[rotary_position_rotator_core] ERROR");
    $finish;
  end

endmodule
